@@ rtl/avs_pkg.sv @@
// Shared types and constants for the aligned value search block.
package avs_pkg;

  localparam int unsigned MAX_VALUE_BYTES = 16;
  localparam int unsigned ADDRESS_BITS    = 48;
  localparam int unsigned IDX_W           = $clog2(MAX_VALUE_BYTES);
  localparam int unsigned SIZE_W          = 5;
  localparam int unsigned COUNT_W         = 32;
  localparam int unsigned VALUE_W         = 128;
  localparam int unsigned APB_DW          = 64;
  localparam int unsigned APB_AW          = 5;
  localparam int unsigned REG_IDX_W       = 2;

  // register index codes (byte address is 8 * index)
  localparam logic [REG_IDX_W-1:0] REG_VALUE_LOW  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_VALUE_HIGH = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_VALUE_SIZE = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_BASE       = 2'd3;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic                    found;
    logic [ADDRESS_BITS-1:0] match_address;
    logic                    region_done;
    logic [COUNT_W-1:0]      match_count;
  } out_t;

  typedef struct packed {
    logic [63:0]             value_low_bytes;
    logic [63:0]             value_high_bytes;
    logic [SIZE_W-1:0]       value_size;
    logic [ADDRESS_BITS-1:0] region_base;
  } cfg_t;

endpackage

@@ rtl/avs_cell.sv @@
// One window cell: holds a byte and its fill flag, compares the byte moving in.
module avs_cell (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       shift_i,
  input  logic       clear_i,
  input  logic [7:0] byte_i,
  input  logic       valid_i,
  input  logic [7:0] ref_byte_i,
  output logic [7:0] byte_o,
  output logic       valid_o,
  output logic       hit_o
);

  logic [7:0] byte_q;
  logic       valid_q;

  // compare on the incoming side: this is the window content after the shift
  assign hit_o = (byte_i == ref_byte_i);

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      byte_q <= byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (shift_i) begin
      valid_q <= valid_i & ~clear_i;
    end
  end

  assign byte_o  = byte_q;
  assign valid_o = valid_q;

endmodule

@@ rtl/avs_regs.sv @@
// APB register file holding the search value, its size and the region base.
module avs_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [avs_pkg::APB_AW-1:0]        paddr,
  input  logic [avs_pkg::APB_DW-1:0]        pwdata,
  output logic [avs_pkg::APB_DW-1:0]        prdata,
  output logic                              pready,
  output avs_pkg::cfg_t                     cfg_o
);

  avs_pkg::cfg_t                      cfg_q;
  logic [avs_pkg::REG_IDX_W-1:0]      reg_idx;
  logic                               wr_en;

  assign reg_idx = paddr[avs_pkg::APB_AW-1:3];
  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.value_low_bytes  <= '0;
      cfg_q.value_high_bytes <= '0;
      cfg_q.value_size       <= avs_pkg::SIZE_RESET;
      cfg_q.region_base      <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        avs_pkg::REG_VALUE_LOW:  cfg_q.value_low_bytes  <= pwdata;
        avs_pkg::REG_VALUE_HIGH: cfg_q.value_high_bytes <= pwdata;
        avs_pkg::REG_VALUE_SIZE: cfg_q.value_size <= pwdata[avs_pkg::SIZE_W-1:0];
        avs_pkg::REG_BASE: cfg_q.region_base <= pwdata[avs_pkg::ADDRESS_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      avs_pkg::REG_VALUE_LOW:  prdata = cfg_q.value_low_bytes;
      avs_pkg::REG_VALUE_HIGH: prdata = cfg_q.value_high_bytes;
      avs_pkg::REG_VALUE_SIZE: prdata = avs_pkg::APB_DW'(cfg_q.value_size);
      avs_pkg::REG_BASE:       prdata = avs_pkg::APB_DW'(cfg_q.region_base);
      default:                 prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/aligned_value_search.sv @@
// Top level: streaming byte pattern search over a row of window cells.
//
//  channel | direction | handshake          | payload
//  in      | input     | in_valid_i/in_stall_o   | avs_pkg::in_t  (data_byte, last_byte)
//  out     | output    | out_valid_o/out_stall_i | avs_pkg::out_t (found, address, done, count)
//  cfg     | input     | APB psel/penable/pready | 64-bit registers at 8 * index
//
// One byte per cycle while in_stall_o is low; the window row shifts once per accepted transfer.
// A result reaches the output register through the compare stage, loaded at the
// accepting edge, then the base + start address add.
// Reset empties the window and zeroes offset and count; no clearing pass.
// Output stall backs up through the two stages; input stalls only when both are full.
module aligned_value_search (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  avs_pkg::in_t                  in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output avs_pkg::out_t                 out_data_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [avs_pkg::APB_AW-1:0]    paddr,
  input  logic [avs_pkg::APB_DW-1:0]    pwdata,
  output logic [avs_pkg::APB_DW-1:0]    prdata,
  output logic                          pready
);

  localparam int unsigned N  = avs_pkg::MAX_VALUE_BYTES;
  localparam int unsigned AB = avs_pkg::ADDRESS_BITS;
  localparam int unsigned CW = avs_pkg::COUNT_W;
  localparam int unsigned IW = avs_pkg::IDX_W;

  avs_pkg::cfg_t cfg;

  avs_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // effective size, kept as size - 1
  logic [IW-1:0]              size_m1;
  logic [avs_pkg::VALUE_W-1:0] value_vec;

  always_comb begin
    if (cfg.value_size == '0) begin
      size_m1 = '0;
    end else if (cfg.value_size > avs_pkg::SIZE_W'(N)) begin
      size_m1 = IW'(N - 1);
    end else begin
      size_m1 = IW'(cfg.value_size - avs_pkg::SIZE_W'(1));
    end
  end

  assign value_vec = {cfg.value_high_bytes, cfg.value_low_bytes};

  // pipeline handshake
  logic in_accept;
  logic a_valid_q, b_valid_q;
  logic b_can, a_can;

  assign b_can      = ~b_valid_q | ~out_stall_i;
  assign a_can      = ~a_valid_q | b_can;
  assign in_stall_o = ~a_can;
  assign in_accept  = in_valid_i & a_can;

  // cell row
  logic [7:0]    cell_byte [N];
  logic [N-1:0]  cell_valid;
  logic [7:0]    cell_in_byte [N];
  logic [N-1:0]  cell_in_valid;
  logic [N-1:0]  cell_hit;
  logic [N-1:0]  cell_need;
  logic [7:0]    ref_byte [N];

  for (genvar k = 0; k < N; k++) begin : g_cell
    logic [IW-1:0] sel;

    if (k == 0) begin : g_head
      assign cell_in_byte[k]  = in_data_i.data_byte;
      assign cell_in_valid[k] = 1'b1;
    end else begin : g_body
      assign cell_in_byte[k]  = cell_byte[k-1];
      assign cell_in_valid[k] = cell_valid[k-1];
    end

    // cell k lines up with value byte (size - 1 - k)
    assign sel         = size_m1 - IW'(k);
    assign ref_byte[k] = value_vec[8*sel +: 8];
    assign cell_need[k] = (IW'(k) <= size_m1);

    avs_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .shift_i    (in_accept),
      .clear_i    (in_data_i.last_byte),
      .byte_i     (cell_in_byte[k]),
      .valid_i    (cell_in_valid[k]),
      .ref_byte_i (ref_byte[k]),
      .byte_o     (cell_byte[k]),
      .valid_o    (cell_valid[k]),
      .hit_o      (cell_hit[k])
    );
  end

  // region state
  logic [AB-1:0] offset_q;
  logic [CW-1:0] count_q;
  logic [AB-1:0] start;
  logic          gate_ok;
  logic          match;
  logic [CW-1:0] count_next;

  assign start = offset_q - AB'(size_m1);

  always_comb begin
    case (size_m1)
      IW'(7):  gate_ok = (start[2:0] == 3'd0);
      IW'(3):  gate_ok = (start[1:0] == 2'd0);
      IW'(1):  gate_ok = (start[1:0] != 2'd3);
      default: gate_ok = 1'b1;
    endcase
  end

  assign match = cell_in_valid[size_m1] & gate_ok & (&(cell_hit | ~cell_need));
  assign count_next = (match && count_q != '1) ? count_q + CW'(1) : count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= '0;
      count_q  <= '0;
    end else if (in_accept) begin
      offset_q <= in_data_i.last_byte ? '0 : offset_q + AB'(1);
      count_q  <= in_data_i.last_byte ? '0 : count_next;
    end
  end

  // compare stage
  logic          a_found_q;
  logic          a_last_q;
  logic [AB-1:0] a_start_q;
  logic [CW-1:0] a_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (a_can) begin
      a_valid_q <= in_accept & (match | in_data_i.last_byte);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      a_found_q <= match;
      a_last_q  <= in_data_i.last_byte;
      a_start_q <= start;
      a_count_q <= count_next;
    end
  end

  // address stage / output register
  avs_pkg::out_t b_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (b_can) begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_can && a_valid_q) begin
      b_data_q.found         <= a_found_q;
      b_data_q.match_address <= a_found_q ? cfg.region_base + a_start_q : '0;
      b_data_q.region_done   <= a_last_q;
      b_data_q.match_count   <= a_count_q;
    end
  end

  assign out_valid_o = b_valid_q;
  assign out_data_o  = b_data_q;

  // checks
  a_result_has_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.found || out_data_o.region_done))
    else $error("result with neither match nor region close");

  a_found_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.found) |-> (out_data_o.match_count != '0))
    else $error("match reported with zero count");

  a_miss_addr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.found) |-> (out_data_o.match_address == '0))
    else $error("nonzero address without a match");

  a_close_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && in_data_i.last_byte) |=> (cell_valid == '0 && offset_q == '0))
    else $error("window not emptied after region close");

endmodule
